// File: design/tlsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsm_pkg: shared types and constants of the two-list sorted merge
// Opcodes, stream field widths and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package tlsm_pkg;

  localparam int OPCODE_W  = 2;
  localparam int FIELD_W   = 32;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 32;

  localparam logic [OPCODE_W-1:0] OP_PUSH_FIRST  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_SECOND = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_MERGE       = 2'd2;

  typedef struct packed {
    logic push_first;
    logic push_second;
    logic start;
    logic step;
  } tlsm_cmd_t;

  typedef struct packed {
    logic empty;
    logic final_pick;
    logic out_free;
  } tlsm_sts_t;

endpackage

// File: design/tlsm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsm_ctrl: sequencer of the two-list sorted merge
// Decodes input beats into push and merge commands and steps the datapath
// through the emission of a merged run.
// ----------------------------------------------------------------------------
module tlsm_ctrl
  import tlsm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [OPCODE_W-1:0] opcode,
  input  tlsm_sts_t           sts,
  output tlsm_cmd_t           cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;
  logic accept;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (opcode == OP_PUSH_FIRST) begin
            cmd.push_first = 1'b1;
          end else if (opcode == OP_PUSH_SECOND) begin
            cmd.push_second = 1'b1;
          end else if (opcode == OP_MERGE && !sts.empty) begin
            cmd.start  = 1'b1;
            state_next = ST_EMIT;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        cmd.step = sts.out_free;
        if (sts.out_free && sts.final_pick) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/tlsm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsm_datapath: list stores, read pointers and output register
// Holds both lists in synchronous memories, compares the two heads and
// drives the result beat register.
// ----------------------------------------------------------------------------
module tlsm_datapath
  import tlsm_pkg::*;
#(
  parameter int LIST_DEPTH = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tlsm_cmd_t            cmd,
  output tlsm_sts_t            sts,
  input  logic [FIELD_W-1:0]   value,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast
);

  localparam int CW    = $clog2(LIST_DEPTH + 1);
  localparam int AW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int EXT_W = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;

  logic [DATA_WIDTH-1:0] first_mem  [LIST_DEPTH];
  logic [DATA_WIDTH-1:0] second_mem [LIST_DEPTH];

  logic [CW-1:0] first_count;
  logic [CW-1:0] second_count;
  logic [CW-1:0] rd1;
  logic [CW-1:0] rd2;
  logic [CW-1:0] rd1_next;
  logic [CW-1:0] rd2_next;

  logic signed [DATA_WIDTH-1:0] head1;
  logic signed [DATA_WIDTH-1:0] head2;
  logic signed [DATA_WIDTH-1:0] pick;
  logic signed [EXT_W-1:0]      pick_ext;
  logic [EXT_W-1:0]             value_ext;
  logic [DATA_WIDTH-1:0]        data_in;

  logic          first_left;
  logic          second_left;
  logic          take1;
  logic [CW:0]   picked_sum;
  logic [CW:0]   total_sum;

  assign value_ext = EXT_W'(value);
  assign data_in   = value_ext[DATA_WIDTH-1:0];

  assign first_left  = (rd1 != first_count);
  assign second_left = (rd2 != second_count);
  assign take1       = first_left && (!second_left || (head1 < head2));
  assign pick        = take1 ? head1 : head2;
  assign pick_ext    = EXT_W'(pick);

  assign picked_sum = {1'b0, rd1} + {1'b0, rd2} + (CW + 1)'(1);
  assign total_sum  = {1'b0, first_count} + {1'b0, second_count};

  assign sts.empty      = (first_count == '0) && (second_count == '0);
  assign sts.final_pick = (picked_sum == total_sum);
  assign sts.out_free   = !m_tvalid || m_tready;

  always_comb begin
    rd1_next = rd1;
    rd2_next = rd2;
    if (cmd.start) begin
      rd1_next = '0;
      rd2_next = '0;
    end else if (cmd.step) begin
      if (take1) begin
        rd1_next = rd1 + CW'(1);
      end else begin
        rd2_next = rd2 + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_first && first_count != CW'(LIST_DEPTH)) begin
      first_mem[first_count[AW-1:0]] <= data_in;
    end
    head1 <= first_mem[rd1_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.push_second && second_count != CW'(LIST_DEPTH)) begin
      second_mem[second_count[AW-1:0]] <= data_in;
    end
    head2 <= second_mem[rd2_next[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    rd1 <= rd1_next;
    rd2 <= rd2_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
    end else if (cmd.step && sts.final_pick) begin
      first_count  <= '0;
      second_count <= '0;
    end else begin
      if (cmd.push_first && first_count != CW'(LIST_DEPTH)) begin
        first_count <= first_count + CW'(1);
      end
      if (cmd.push_second && second_count != CW'(LIST_DEPTH)) begin
        second_count <= second_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      m_tdata <= pick_ext[M_TDATA_W-1:0];
      m_tlast <= sts.final_pick;
    end
  end

endmodule

// File: design/two_list_sorted_merge_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_list_sorted_merge_top: merge of two sorted lists
// Channel  Dir  Beat contents
// s_*      in   tdata[1:0] opcode, tdata[33:2] value, upper bits zero
// m_*      out  tdata[31:0] merged_value, tlast marks the final value
//
// A push beat leaves the input ready. A merge beat on lists that are not both
// empty first registers both list heads, then emits one value per cycle, one
// memory read per list per cycle, for as long as the output is not stalled.
// The input is held off while a run is emitted. Reset empties both lists and clears the output valid.
// ----------------------------------------------------------------------------
module two_list_sorted_merge_top
  import tlsm_pkg::*;
#(
  parameter int LIST_DEPTH = 32,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // opcode, value
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // merged_value
  output logic                 m_tlast
);

  tlsm_cmd_t cmd;
  tlsm_sts_t sts;

  tlsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .opcode   (s_tdata[OPCODE_W-1:0]),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlsm_datapath #(
    .LIST_DEPTH (LIST_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .value    (s_tdata[OPCODE_W+FIELD_W-1:OPCODE_W]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: design/tlsm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsm_checker: port-level checks of the two-list sorted merge
// Watches the stream ports and flags broken runs, changed stalled beats, blocked input after a push and a busy reset.
// ----------------------------------------------------------------------------
module tlsm_checker
  import tlsm_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Stalled result beat changed.");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("Input taken in the middle of a merged run.");

  a_push: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tdata[OPCODE_W-1:0] == OP_PUSH_FIRST ||
      s_tdata[OPCODE_W-1:0] == OP_PUSH_SECOND) |=> s_tready)
    else $error("Push beat blocked the input.");

  a_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid)
    else $error("Merged run broke off before its last beat.");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("Reset left the block busy.");

endmodule

bind two_list_sorted_merge_top tlsm_checker u_tlsm_checker (.*);

// File: tb/sv/tb_two_list_sorted_merge_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_two_list_sorted_merge_top: self-checking bench for the two-list merge
// Push and merge beats are queued by an initial block and presented by a
// clocked driver. Each accepted beat updates a local copy of both lists, and
// a merge beat queues the merged values it must produce. A clocked monitor
// compares every output beat with the oldest queued value. Both sides stall
// at random, apart from one calm stretch in the middle of the run.
// ----------------------------------------------------------------------------
module tb_two_list_sorted_merge_top;
  import tlsm_pkg::*;

  localparam int LIST_DEPTH = 32;
  localparam int IDLE_LIMIT = 2000;
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [OPCODE_W-1:0] opcode;
    logic [FIELD_W-1:0]  value;
    bit                  hold;
  } list_beat_t;

  typedef struct {
    logic [FIELD_W-1:0] merged_value;
    logic               last;
  } merged_beat_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  list_beat_t   pending_beats[$];
  list_beat_t   shown_beat;
  merged_beat_t merged_due[$];
  logic signed [FIELD_W-1:0] first_list[$];
  logic signed [FIELD_W-1:0] second_list[$];
  int unsigned  beats_sent = 0;
  int unsigned  errors = 0;
  int unsigned  idle_cycles = 0;
  logic         calm;

  two_list_sorted_merge_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  assign calm = (beats_sent >= 150) && (beats_sent < 250);

  // Applies one accepted beat to the list copies and queues merged values.
  task automatic track_beat(input list_beat_t b);
    int unsigned total;
    merged_beat_t mb;
    begin
      case (b.opcode)
        OP_PUSH_FIRST: begin
          if (first_list.size() < LIST_DEPTH) first_list.push_back(b.value);
        end
        OP_PUSH_SECOND: begin
          if (second_list.size() < LIST_DEPTH) second_list.push_back(b.value);
        end
        OP_MERGE: begin
          total = first_list.size() + second_list.size();
          for (int unsigned n = 0; n < total; n++) begin
            if (first_list.size() == 0) begin
              mb.merged_value = second_list.pop_front();
            end else if (second_list.size() == 0) begin
              mb.merged_value = first_list.pop_front();
            end else if (first_list[0] < second_list[0]) begin
              mb.merged_value = first_list.pop_front();
            end else begin
              mb.merged_value = second_list.pop_front();
            end
            mb.last = (n + 1 == total);
            merged_due.push_back(mb);
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        track_beat(shown_beat);
        beats_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_beats.size() != 0 &&
            (!pending_beats[0].hold || merged_due.size() == 0) &&
            (calm || $urandom_range(99, 0) >= 22)) begin
          shown_beat = pending_beats.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {{(S_TDATA_W - FIELD_W - OPCODE_W){1'b0}},
                       shown_beat.value, shown_beat.opcode};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    merged_beat_t exp_beat;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (merged_due.size() == 0) begin
          $error("unexpected merged beat: merged_value %0d last %0b",
                 $signed(m_tdata), m_tlast);
          errors++;
        end else begin
          exp_beat = merged_due.pop_front();
          if (m_tdata !== exp_beat.merged_value) begin
            $error("merged_value: expected %0d, got %0d",
                   $signed(exp_beat.merged_value), $signed(m_tdata));
            errors++;
          end
          if (m_tlast !== exp_beat.last) begin
            $error("last: expected %0b, got %0b", exp_beat.last, m_tlast);
            errors++;
          end
        end
      end
      m_tready <= calm || ($urandom_range(99, 0) >= 22);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("** two_list_sorted_merge_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_beat(input logic [OPCODE_W-1:0] op, input logic [FIELD_W-1:0] val,
                          input bit hold);
    list_beat_t b;
    begin
      b.opcode = op;
      b.value  = val;
      b.hold   = hold;
      pending_beats.push_back(b);
    end
  endtask

  function automatic logic [FIELD_W-1:0] pick_value(input bit narrow);
    if (narrow) return FIELD_W'($signed($urandom_range(8, 0)) - 4);
    return $urandom;
  endfunction

  initial begin
    int first_vals[$];
    int second_vals[$];
    int unsigned n1;
    int unsigned n2;
    int unsigned i1;
    int unsigned i2;
    bit narrow;

    // Merge of two empty lists, then an ignored opcode.
    add_beat(OP_MERGE, 32'h0000_0000, 1'b0);
    add_beat(OP_UNUSED, 32'hFFFF_FFFF, 1'b0);
    // Extremes and ties across both lists.
    add_beat(OP_PUSH_FIRST, 32'h8000_0000, 1'b0);
    add_beat(OP_PUSH_SECOND, 32'h8000_0000, 1'b0);
    add_beat(OP_PUSH_FIRST, 32'hFFFF_FFFF, 1'b0);
    add_beat(OP_PUSH_FIRST, 32'h0000_0000, 1'b0);
    add_beat(OP_PUSH_SECOND, 32'h0000_0000, 1'b0);
    add_beat(OP_PUSH_SECOND, 32'h0000_0005, 1'b0);
    add_beat(OP_PUSH_FIRST, 32'h7FFF_FFFF, 1'b0);
    add_beat(OP_PUSH_SECOND, 32'h7FFF_FFFF, 1'b0);
    add_beat(OP_MERGE, 32'hFFFF_FFFF, 1'b0);
    // Only the first list holds data; the sender waits for the previous run.
    add_beat(OP_PUSH_FIRST, 32'h0000_0007, 1'b1);
    add_beat(OP_MERGE, 32'h0000_0000, 1'b0);
    // Only the second list holds data.
    add_beat(OP_PUSH_SECOND, 32'h0000_0003, 1'b0);
    add_beat(OP_PUSH_SECOND, 32'h0000_0004, 1'b0);
    add_beat(OP_MERGE, 32'h0000_0000, 1'b0);
    // Unsorted lists still follow the head comparison.
    add_beat(OP_PUSH_FIRST, 32'h0000_000A, 1'b0);
    add_beat(OP_PUSH_FIRST, 32'h0000_0002, 1'b0);
    add_beat(OP_PUSH_SECOND, 32'h0000_0005, 1'b0);
    add_beat(OP_PUSH_SECOND, 32'h0000_0001, 1'b0);
    add_beat(OP_MERGE, 32'h0000_0000, 1'b0);
    add_beat(OP_UNUSED, 32'h5555_AAAA, 1'b0);

    while (pending_beats.size() < 372) begin
      if ($urandom_range(99, 0) < 80) begin
        narrow = ($urandom_range(2, 0) == 0);
        if ($urandom_range(11, 0) == 0) begin
          n1 = $urandom_range(LIST_DEPTH + 2, LIST_DEPTH - 4);
          n2 = $urandom_range(LIST_DEPTH + 2, 0);
        end else begin
          n1 = $urandom_range(6, 0);
          n2 = $urandom_range(6, 0);
        end
        first_vals.delete();
        second_vals.delete();
        for (int unsigned k = 0; k < n1; k++) first_vals.push_back(int'(pick_value(narrow)));
        for (int unsigned k = 0; k < n2; k++) second_vals.push_back(int'(pick_value(narrow)));
        if ($urandom_range(9, 0) != 0) begin
          first_vals.sort();
          second_vals.sort();
        end
        i1 = 0;
        i2 = 0;
        while (i1 < n1 || i2 < n2) begin
          if (i2 >= n2 || (i1 < n1 && $urandom_range(1, 0) == 1)) begin
            add_beat(OP_PUSH_FIRST, first_vals[i1], 1'b0);
            i1++;
          end else begin
            add_beat(OP_PUSH_SECOND, second_vals[i2], 1'b0);
            i2++;
          end
          if ($urandom_range(29, 0) == 0) add_beat(OP_UNUSED, $urandom, 1'b0);
        end
        add_beat(OP_MERGE, $urandom, ($urandom_range(9, 0) == 0));
      end else begin
        add_beat(OPCODE_W'($urandom_range(3, 0)), $urandom, 1'b0);
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || s_tvalid) @(posedge clk);
    while (merged_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (errors == 0) begin
      $display("** two_list_sorted_merge_top: PASSED **");
    end else begin
      $display("** two_list_sorted_merge_top: FAILED **");
    end
    $finish;
  end

endmodule

// File: sim.f
design/tlsm_pkg.sv
design/tlsm_ctrl.sv
design/tlsm_datapath.sv
design/two_list_sorted_merge_top.sv
design/tlsm_checker.sv
tb/sv/tb_two_list_sorted_merge_top.sv
